FILE: hdl/region_cache_timestamp_lru_unit_macros.svh
// Assertion macros for the region cache timestamp LRU unit.
// Included by the top level; no other dependencies.
`ifndef REGION_CACHE_TIMESTAMP_LRU_UNIT_MACROS_SVH
`define REGION_CACHE_TIMESTAMP_LRU_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RLRU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/rlru_pkg.sv
// Shared types and constants for the region cache timestamp LRU unit.
// No dependencies.
package rlru_pkg;

    localparam int SLOTS_DEF       = 10;
    localparam int REGION_BITS_DEF = 14;
    localparam int TIME_BITS       = 32;
    localparam int STATUS_BITS     = 3;

    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT      = 3'd0,
        ST_FREE     = 3'd1,
        ST_EVICT    = 3'd2,
        ST_FAIL     = 3'd3,
        ST_OFF      = 3'd4,
        ST_NOVICTIM = 3'd5
    } rlru_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } rlru_state_t;

    // What the scan record has found so far.
    typedef struct packed {
        logic hit;
        logic free_found;
        logic old_found;
    } scan_flags_t;

    // Write command broadcast to the cell row.
    typedef struct packed {
        logic clear;
        logic write;
        logic set_valid;
    } wr_ctl_t;

endpackage

FILE: hdl/rlru_req_if.sv
// Request channel: valid/ready with region number, time and load flag.
// Depends on rlru_pkg.
interface rlru_req_if
    import rlru_pkg::*;
#(
    parameter int REGION_BITS = REGION_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [REGION_BITS-1:0] region_number;
    logic [TIME_BITS-1:0]   now_seconds;
    logic                   load_ok;

    modport source (output valid, output region_number, output now_seconds,
                    output load_ok, input ready);
    modport sink   (input valid, input region_number, input now_seconds,
                    input load_ok, output ready);
endinterface

FILE: hdl/rlru_rsp_if.sv
// Response channel: valid/ready with status, slot and eviction report.
// Depends on rlru_pkg.
interface rlru_rsp_if
    import rlru_pkg::*;
#(
    parameter int REGION_BITS = REGION_BITS_DEF,
    parameter int SLOT_BITS   = $clog2(SLOTS_DEF)
) ();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot;
    logic                   evicted_valid;
    logic [REGION_BITS-1:0] evicted_region;

    modport source (output valid, output status, output slot,
                    output evicted_valid, output evicted_region, input ready);
    modport sink   (input valid, input status, input slot,
                    input evicted_valid, input evicted_region, output ready);
endinterface

FILE: hdl/rlru_cell.sv
// One slot of the tag store plus one stage of the scan record.
// Depends on rlru_pkg.
module rlru_cell
    import rlru_pkg::*;
#(
    parameter int REGION_BITS = REGION_BITS_DEF,
    parameter int SLOT_BITS   = $clog2(SLOTS_DEF),
    parameter int INDEX       = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REGION_BITS-1:0] query_region,
    // scan record from the left neighbor
    input  logic                   tok_in,
    input  scan_flags_t            flags_in,
    input  logic [SLOT_BITS-1:0]   hit_idx_in,
    input  logic [SLOT_BITS-1:0]   free_idx_in,
    input  logic [SLOT_BITS-1:0]   old_idx_in,
    input  logic [TIME_BITS-1:0]   best_in,
    input  logic [REGION_BITS-1:0] old_region_in,
    // scan record to the right neighbor
    output logic                   tok_out,
    output scan_flags_t            flags_out,
    output logic [SLOT_BITS-1:0]   hit_idx_out,
    output logic [SLOT_BITS-1:0]   free_idx_out,
    output logic [SLOT_BITS-1:0]   old_idx_out,
    output logic [TIME_BITS-1:0]   best_out,
    output logic [REGION_BITS-1:0] old_region_out,
    // write command
    input  wr_ctl_t                wr_ctl,
    input  logic [SLOT_BITS-1:0]   wr_idx,
    input  logic [REGION_BITS-1:0] wr_region,
    input  logic [TIME_BITS-1:0]   wr_stamp
);

    localparam logic [SLOT_BITS-1:0] MY_IDX = SLOT_BITS'(INDEX);

    logic                   valid_reg;
    logic [REGION_BITS-1:0] region_reg;
    logic [TIME_BITS-1:0]   stamp_reg;

    logic                   tok_reg;
    scan_flags_t            flags_reg, flags_next;
    logic [SLOT_BITS-1:0]   hit_idx_reg, hit_idx_next;
    logic [SLOT_BITS-1:0]   free_idx_reg, free_idx_next;
    logic [SLOT_BITS-1:0]   old_idx_reg, old_idx_next;
    logic [TIME_BITS-1:0]   best_reg, best_next;
    logic [REGION_BITS-1:0] old_region_reg, old_region_next;

    logic match;
    logic wr_me;

    assign match = valid_reg && (region_reg == query_region);
    assign wr_me = wr_ctl.write && (wr_idx == MY_IDX);

    // Fold this slot into the record; nothing changes once a hit is found.
    always_comb
    begin
        flags_next      = flags_in;
        hit_idx_next    = hit_idx_in;
        free_idx_next   = free_idx_in;
        old_idx_next    = old_idx_in;
        best_next       = best_in;
        old_region_next = old_region_in;
        if (!flags_in.hit)
        begin
            if (match)
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = MY_IDX;
            end
            else if (!valid_reg)
            begin
                flags_next.free_found = 1'b1;
                free_idx_next         = MY_IDX;
            end
            else if (stamp_reg < best_in)
            begin
                flags_next.old_found = 1'b1;
                old_idx_next         = MY_IDX;
                best_next            = stamp_reg;
                old_region_next      = region_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (wr_ctl.clear)
                valid_reg <= 1'b0;
            else if (wr_me)
                valid_reg <= wr_ctl.set_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ctl.clear)
        begin
            region_reg <= '0;
            stamp_reg  <= '0;
        end
        else if (wr_me)
        begin
            region_reg <= wr_ctl.set_valid ? wr_region : '0;
            stamp_reg  <= wr_ctl.set_valid ? wr_stamp : '0;
        end
        // record only moves with the token, so the last stage holds its answer
        if (tok_in)
        begin
            flags_reg      <= flags_next;
            hit_idx_reg    <= hit_idx_next;
            free_idx_reg   <= free_idx_next;
            old_idx_reg    <= old_idx_next;
            best_reg       <= best_next;
            old_region_reg <= old_region_next;
        end
    end

    assign tok_out        = tok_reg;
    assign flags_out      = flags_reg;
    assign hit_idx_out    = hit_idx_reg;
    assign free_idx_out   = free_idx_reg;
    assign old_idx_out    = old_idx_reg;
    assign best_out       = best_reg;
    assign old_region_out = old_region_reg;

endmodule

FILE: hdl/region_cache_timestamp_lru_unit.sv
// Region cache tag store with timestamp LRU replacement, top level.
// Depends on rlru_pkg, rlru_req_if, rlru_rsp_if, rlru_cell and the macros header.
//
// Usage:
//   req  - request transactions (region_number, now_seconds, load_ok), valid/ready.
//   rsp  - one response transaction per request (status, slot, evicted_valid,
//          evicted_region), valid/ready, from an output register.
//   cfg  - cfg_wr_en/cfg_wr_data write the store_enabled bit; every write
//          invalidates all slots. Write only while no request is in flight.
// Each slot lives in an rlru_cell; the cells form a row. A scan record walks
// the row one cell per cycle, collecting first hit, highest free slot and
// oldest timestamp, then one write command updates the chosen slot if the outcome needs a write.
// The response is registered once the record has left the last cell. A new
// request is accepted only after the previous one has committed, since
// req.ready is high only while idle.
// Reset: all slots invalid, store disabled, no response pending.
// Stall: while a response waits, the next request may be accepted and scanned;
// its commit waits until the output register frees up.
`include "region_cache_timestamp_lru_unit_macros.svh"

module region_cache_timestamp_lru_unit
    import rlru_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int REGION_BITS = REGION_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    rlru_req_if.sink       req,
    rlru_rsp_if.source     rsp,
    input  logic           cfg_wr_en,
    input  logic           cfg_wr_data
);

    localparam int SLOT_BITS = $clog2(SLOTS);

    // ---------------- control state ----------------
    rlru_state_t state_reg, state_next;
    logic        enabled_reg;
    logic        start_reg;

    // captured request
    logic [REGION_BITS-1:0] req_region_reg;
    logic [TIME_BITS-1:0]   req_time_reg;
    logic                   req_load_ok_reg;

    // output register
    logic                   out_valid_reg;
    rlru_status_t           status_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic                   evv_reg;
    logic [REGION_BITS-1:0] evr_reg;

    // ---------------- scan record along the row ----------------
    logic [SLOTS:0]         tok_w;
    scan_flags_t            flags_w      [SLOTS+1];
    logic [SLOT_BITS-1:0]   hit_idx_w    [SLOTS+1];
    logic [SLOT_BITS-1:0]   free_idx_w   [SLOTS+1];
    logic [SLOT_BITS-1:0]   old_idx_w    [SLOTS+1];
    logic [TIME_BITS-1:0]   best_w       [SLOTS+1];
    logic [REGION_BITS-1:0] old_region_w [SLOTS+1];

    // write command to the row
    wr_ctl_t                wr_ctl;
    logic [SLOT_BITS-1:0]   wr_idx;

    logic                   accept;
    logic                   out_free;
    logic                   commit;
    logic                   last_tok;

    // decided response
    rlru_status_t           res_status;
    logic [SLOT_BITS-1:0]   res_slot;
    logic                   res_evv;
    logic [REGION_BITS-1:0] res_evr;
    logic                   res_write;
    logic                   res_set_valid;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign last_tok = tok_w[SLOTS];

    // head of the row: empty record, best starts at the all-ones time
    assign tok_w[0]        = start_reg;
    assign flags_w[0]      = '0;
    assign hit_idx_w[0]    = '0;
    assign free_idx_w[0]   = '0;
    assign old_idx_w[0]    = '0;
    assign best_w[0]       = TIME_TOP;
    assign old_region_w[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            rlru_cell #(
                .REGION_BITS (REGION_BITS),
                .SLOT_BITS   (SLOT_BITS),
                .INDEX       (gi)
            ) u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .query_region   (req_region_reg),
                .tok_in         (tok_w[gi]),
                .flags_in       (flags_w[gi]),
                .hit_idx_in     (hit_idx_w[gi]),
                .free_idx_in    (free_idx_w[gi]),
                .old_idx_in     (old_idx_w[gi]),
                .best_in        (best_w[gi]),
                .old_region_in  (old_region_w[gi]),
                .tok_out        (tok_w[gi+1]),
                .flags_out      (flags_w[gi+1]),
                .hit_idx_out    (hit_idx_w[gi+1]),
                .free_idx_out   (free_idx_w[gi+1]),
                .old_idx_out    (old_idx_w[gi+1]),
                .best_out       (best_w[gi+1]),
                .old_region_out (old_region_w[gi+1]),
                .wr_ctl         (wr_ctl),
                .wr_idx         (wr_idx),
                .wr_region      (req_region_reg),
                .wr_stamp       (req_time_reg)
            );
        end
    endgenerate

    // ---------------- decision from the finished record ----------------
    always_comb
    begin
        res_status    = ST_OFF;
        res_slot      = '0;
        res_evv       = 1'b0;
        res_evr       = '0;
        res_write     = 1'b0;
        res_set_valid = 1'b0;
        wr_idx        = '0;
        if (!enabled_reg)
        begin
            res_status = ST_OFF;
        end
        else if (flags_w[SLOTS].hit)
        begin
            // refresh timestamp of the matching slot
            res_status    = ST_HIT;
            res_slot      = hit_idx_w[SLOTS];
            res_write     = 1'b1;
            res_set_valid = 1'b1;
            wr_idx        = hit_idx_w[SLOTS];
        end
        else if (flags_w[SLOTS].free_found)
        begin
            wr_idx = free_idx_w[SLOTS];
            if (req_load_ok_reg)
            begin
                res_status    = ST_FREE;
                res_slot      = free_idx_w[SLOTS];
                res_write     = 1'b1;
                res_set_valid = 1'b1;
            end
            else
            begin
                res_status = ST_FAIL;
            end
        end
        else if (flags_w[SLOTS].old_found)
        begin
            // evict; on a failed load the victim is left empty
            wr_idx        = old_idx_w[SLOTS];
            res_evv       = 1'b1;
            res_evr       = old_region_w[SLOTS];
            res_write     = 1'b1;
            res_set_valid = req_load_ok_reg;
            if (req_load_ok_reg)
            begin
                res_status = ST_EVICT;
                res_slot   = old_idx_w[SLOTS];
            end
            else
            begin
                res_status = ST_FAIL;
            end
        end
        else
        begin
            // every slot full and stamped with the all-ones time
            res_status = ST_NOVICTIM;
        end
    end

    always_comb
    begin
        wr_ctl.clear     = cfg_wr_en;
        wr_ctl.write     = commit && res_write;
        wr_ctl.set_valid = res_set_valid;
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (last_tok)
                begin
                    commit     = out_free;
                    state_next = out_free ? S_IDLE : S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                commit = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enabled_reg   <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= accept;
            if (cfg_wr_en)
                enabled_reg <= cfg_wr_data;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_region_reg  <= req.region_number;
            req_time_reg    <= req.now_seconds;
            req_load_ok_reg <= req.load_ok;
        end
        if (commit)
        begin
            status_reg <= res_status;
            slot_reg   <= res_slot;
            evv_reg    <= res_evv;
            evr_reg    <= res_evr;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = status_reg;
    assign rsp.slot           = slot_reg;
    assign rsp.evicted_valid  = evv_reg;
    assign rsp.evicted_region = evr_reg;

    // ---------------- assertions ----------------
    `RLRU_ASSERT_IMP(a_one_token, clk, rst_n, 1'b1, $onehot0(tok_w[SLOTS:1]),
                     "more than one scan record in the cell row")
    `RLRU_ASSERT_IMP(a_idle_empty, clk, rst_n, state_reg == S_IDLE, tok_w == '0,
                     "scan record in flight while idle")
    `RLRU_ASSERT_NEXT(a_commit_out, clk, rst_n, commit, out_valid_reg,
                      "committed transaction not presented")
    `RLRU_ASSERT_IMP(a_evict_status, clk, rst_n, out_valid_reg && evv_reg,
                     status_reg == ST_EVICT || status_reg == ST_FAIL,
                     "eviction reported with wrong status")

endmodule

FILE: verif/rlru_response_checker.sv
// Response checker for the region cache timestamp LRU unit: predicts every
// lookup from the request and config transactions and compares the responses.
// Depends on rlru_pkg.
module rlru_response_checker
    import rlru_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic [REGION_BITS_DEF-1:0] req_region,
    input  logic [TIME_BITS-1:0]       req_now,
    input  logic                       req_load_ok,
    input  logic                       rsp_valid,
    input  logic                       rsp_ready,
    input  logic [STATUS_BITS-1:0]     rsp_status,
    input  logic [$clog2(SLOTS_DEF)-1:0] rsp_slot,
    input  logic                       rsp_evicted_valid,
    input  logic [REGION_BITS_DEF-1:0] rsp_evicted_region,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_wr_data,
    output int                         fail_count,
    output int                         pending
);

    localparam int SLOT_BITS = $clog2(SLOTS_DEF);

    typedef struct packed {
        rlru_status_t               status;
        logic [SLOT_BITS-1:0]       slot;
        logic                       evicted_valid;
        logic [REGION_BITS_DEF-1:0] evicted_region;
    } lookup_result_t;

    // Shadow tag store
    logic                       store_on;
    logic                       line_valid  [SLOTS_DEF];
    logic [REGION_BITS_DEF-1:0] line_region [SLOTS_DEF];
    logic [TIME_BITS-1:0]       line_stamp  [SLOTS_DEF];

    lookup_result_t predicted_q [$];
    int             errors;

    function automatic void flush_lines();
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            line_valid[i]  = 1'b0;
            line_region[i] = '0;
            line_stamp[i]  = '0;
        end
    endfunction

    // Lookup with hit update, highest free slot fill, oldest-stamp eviction.
    function automatic lookup_result_t predict_lookup(
        input logic [REGION_BITS_DEF-1:0] region,
        input logic [TIME_BITS-1:0]       now,
        input logic                       ok
    );
        lookup_result_t       res;
        int                   free_idx;
        int                   old_idx;
        int                   target;
        logic [TIME_BITS-1:0] best;
        res        = '0;
        res.status = ST_OFF;
        free_idx   = -1;
        old_idx    = -1;
        target     = 0;
        best       = TIME_TOP;
        if (!store_on)
            return res;
        for (int i = 0; i < SLOTS_DEF; i++)
        begin
            if (line_valid[i] && line_region[i] == region)
            begin
                line_stamp[i] = now;
                res.status    = ST_HIT;
                res.slot      = SLOT_BITS'(i);
                return res;
            end
            if (!line_valid[i])
                free_idx = i;
            else if (line_stamp[i] < best)
            begin
                best    = line_stamp[i];
                old_idx = i;
            end
        end
        if (free_idx >= 0)
            target = free_idx;
        else if (old_idx < 0)
        begin
            res.status = ST_NOVICTIM;
            return res;
        end
        else
        begin
            res.evicted_valid   = 1'b1;
            res.evicted_region  = line_region[old_idx];
            line_valid[old_idx]  = 1'b0;
            line_region[old_idx] = '0;
            line_stamp[old_idx]  = '0;
            target = old_idx;
        end
        if (!ok)
        begin
            res.status = ST_FAIL;
            return res;
        end
        line_valid[target]  = 1'b1;
        line_region[target] = region;
        line_stamp[target]  = now;
        res.status = res.evicted_valid ? ST_EVICT : ST_FREE;
        res.slot   = SLOT_BITS'(target);
        return res;
    endfunction

    function automatic int field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        lookup_result_t want;
        if (!rst_n)
        begin
            store_on = 1'b0;
            flush_lines();
            predicted_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                store_on = cfg_wr_data;
                flush_lines();
            end
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response, expected none, actual %0d/%0d/%0d/%0d",
                             $time, rsp_status, rsp_slot, rsp_evicted_valid,
                             rsp_evicted_region);
                end
                else
                begin
                    want = predicted_q.pop_front();
                    errors += field_mismatch("status", 32'(want.status), 32'(rsp_status));
                    errors += field_mismatch("slot", 32'(want.slot), 32'(rsp_slot));
                    errors += field_mismatch("evicted_valid", 32'(want.evicted_valid),
                                             32'(rsp_evicted_valid));
                    errors += field_mismatch("evicted_region", 32'(want.evicted_region),
                                             32'(rsp_evicted_region));
                end
            end
            if (req_valid && req_ready)
                predicted_q.push_back(predict_lookup(req_region, req_now, req_load_ok));
        end
        fail_count <= errors;
        pending    <= predicted_q.size();
    end

endmodule

FILE: verif/tb_region_cache_timestamp_lru_unit.sv
// Testbench top for the region cache timestamp LRU unit: clock, reset,
// request and config stimulus, response back-pressure and the verdict.
// Depends on rlru_pkg, rlru_req_if, rlru_rsp_if and rlru_response_checker.
module tb_region_cache_timestamp_lru_unit;
    import rlru_pkg::*;

    // Slowest legal run is roughly 2000 transactions plus random sender gaps
    // and receiver stalls. The limit leaves a wide margin on top of that.
    localparam int CYCLE_LIMIT   = 400000;
    // Settle for longer than a request takes to come back as a response.
    localparam int SETTLE_CYCLES = 16;
    // Working set a little larger than the ten slots, so that hits,
    // free fills and evictions all come up often.
    localparam int POOL_SIZE     = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 650;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    int   fail_count;
    int   pending;
    int   cycle_count;
    int   req_idle_pct;   // owned by the stimulus process only
    int   rsp_idle_pct;   // read by the response process
    logic hold_request;

    logic [REGION_BITS_DEF-1:0] region_pool [POOL_SIZE];
    logic [TIME_BITS-1:0]       wall_clock;

    rlru_req_if req_ch ();
    rlru_rsp_if rsp_ch ();

    always #4 clk = ~clk;

    region_cache_timestamp_lru_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    rlru_response_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_ch.valid),
        .req_ready          (req_ch.ready),
        .req_region         (req_ch.region_number),
        .req_now            (req_ch.now_seconds),
        .req_load_ok        (req_ch.load_ok),
        .rsp_valid          (rsp_ch.valid),
        .rsp_ready          (rsp_ch.ready),
        .rsp_status         (rsp_ch.status),
        .rsp_slot           (rsp_ch.slot),
        .rsp_evicted_valid  (rsp_ch.evicted_valid),
        .rsp_evicted_region (rsp_ch.evicted_region),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    // One request transaction. Random idle cycles go in front of it; valid
    // then stays high until the block takes it. Valid is never lowered at
    // the accepting edge, so back-to-back transactions keep it high.
    task automatic offer_request(
        input logic [REGION_BITS_DEF-1:0] region,
        input logic [TIME_BITS-1:0]       stamp,
        input logic                       ok
    );
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.region_number <= region;
        req_ch.now_seconds   <= stamp;
        req_ch.load_ok       <= ok;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Config writes only land while the block is idle: stop offering, wait
    // one edge so the checker's count includes the last accepted request,
    // drain every response, then let the block settle.
    task automatic write_store_enable(input logic value);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic refill_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            region_pool[i] = REGION_BITS_DEF'($urandom_range(16383));
    endtask

    // Mostly pool regions with a slowly advancing clock, so the LRU order
    // means something. Saturated stamps pile up in the store and push it
    // into the no-victim case; zero and wild stamps reorder the victims.
    task automatic run_random(input int count);
        logic [REGION_BITS_DEF-1:0] region;
        logic [TIME_BITS-1:0]       stamp;
        logic                       ok;
        int                         pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
                region = region_pool[$urandom_range(POOL_SIZE - 1)];
            else
                region = REGION_BITS_DEF'($urandom_range(16383));
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                wall_clock = wall_clock + $urandom_range(3);
                stamp      = wall_clock;
            end
            else if (pick < 82)
                stamp = TIME_TOP;
            else if (pick < 90)
                stamp = '0;
            else
                stamp = $urandom;
            ok = ($urandom_range(99) < 88);
            offer_request(region, stamp, ok);
        end
    endtask

    // Response side: random stalls at rsp_idle_pct, plus one long hold-off
    // when asked. During the hold-off the sender keeps offering, so the
    // block fills its output register and scan stage and drops req.ready.
    initial
    begin : response_drain
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.region_number <= '0;
        req_ch.now_seconds   <= '0;
        req_ch.load_ok       <= 1'b0;
        rsp_idle_pct         <= 0;
        hold_request         <= 1'b0;
        req_idle_pct = 0;
        wall_clock   = $urandom;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, no idling ----
        // Store comes out of reset disabled.
        offer_request('1, TIME_TOP, 1'b1);
        write_store_enable(1'b1);
        // Free fills from the top slot down, then a failed load into a free slot.
        offer_request('0, '0, 1'b1);
        offer_request('1, TIME_TOP, 1'b1);
        offer_request(REGION_BITS_DEF'(5), TIME_BITS'(1), 1'b0);
        // Hits refresh the stamp; saturate region 0.
        offer_request('0, TIME_BITS'(5), 1'b1);
        offer_request('0, TIME_TOP, 1'b1);
        // Fill the rest with saturated stamps: then nothing can be evicted.
        for (int r = 1; r <= 8; r++)
            offer_request(REGION_BITS_DEF'(r), TIME_TOP, 1'b1);
        offer_request(REGION_BITS_DEF'(100), TIME_BITS'(9), 1'b1);
        // One slot gets an old stamp; a failed load evicts it and leaves it free.
        offer_request(REGION_BITS_DEF'(3), TIME_BITS'(7), 1'b1);
        offer_request(REGION_BITS_DEF'(200), TIME_BITS'(10), 1'b0);
        offer_request(REGION_BITS_DEF'(201), TIME_BITS'(11), 1'b1);
        // Tie on the smallest stamp: the lower slot index loses.
        offer_request(REGION_BITS_DEF'(1), TIME_BITS'(2), 1'b1);
        offer_request(REGION_BITS_DEF'(2), TIME_BITS'(2), 1'b1);
        offer_request(REGION_BITS_DEF'(300), TIME_BITS'(12), 1'b1);
        // Disable clears the store and blocks lookups.
        write_store_enable(1'b0);
        offer_request(REGION_BITS_DEF'(300), TIME_BITS'(13), 1'b1);

        // ---- random phase A: sender idles 33%, receiver 59% ----
        req_idle_pct = 33;
        rsp_idle_pct <= 59;
        write_store_enable(1'b1);
        refill_pool();
        run_random(PHASE_ITEMS);
        // short disabled stretch
        write_store_enable(1'b0);
        run_random(15);

        // ---- random phase B: sender idles 59%, receiver 33% ----
        req_idle_pct = 59;
        rsp_idle_pct <= 33;
        write_store_enable(1'b1);
        refill_pool();
        run_random(PHASE_ITEMS);

        // ---- random phase C: no idling, one long receiver hold-off ----
        req_idle_pct = 0;
        rsp_idle_pct <= 0;
        write_store_enable(1'b1);
        refill_pool();
        hold_request <= 1'b1;
        run_random(PHASE_ITEMS);

        // Drain and settle, then the verdict.
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
